[design/tgf_pkg.sv]
// Shared types, constants and font functions for the text glyph frame buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
package tgf_pkg;

  localparam int unsigned ColumnsDefault = 128;
  localparam int unsigned PagesDefault   = 8;
  localparam int unsigned GlyphW         = 5;
  localparam int unsigned CellW          = 6;
  localparam int unsigned MaxDigits      = 10;
  localparam int unsigned NumBits        = 32;

  localparam logic [7:0] RowTop    = 8'h01;
  localparam logic [7:0] RowBottom = 8'h80;
  localparam logic [7:0] SideCol   = 8'hFF;

  localparam logic [5:0] GlyphColon = 6'd36;
  localparam logic [5:0] GlyphDash  = 6'd37;
  localparam logic [5:0] GlyphBlank = 6'd38;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_CHAR   = 3'd1,
    CMD_NUMBER = 3'd2,
    CMD_BORDER = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_BORDER,
    ST_CONV,
    ST_DIGIT,
    ST_GLYPH,
    ST_READ,
    ST_RDATA,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic sweep_step;
    logic sweep_border;
    logic conv_step;
    logic digit_sel;
    logic digit_next;
    logic glyph_step;
    logic rej_set;
    logic rej_clr;
    logic rd_capture;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       sweep_last;
    logic       conv_last;
    logic       glyph_ok;
    logic       glyph_last;
    logic       digit_last;
    logic       width_ok;
    logic       read_ok;
  } sts_t;

  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c inside {[8'h61:8'h7A]}) c = c - 8'h20;
    if (c inside {[8'h30:8'h39]}) return 6'(c - 8'h30);
    if (c inside {[8'h41:8'h5A]}) return 6'(c - 8'h37);
    if (c == 8'h3A) return GlyphColon;
    if (c == 8'h2D) return GlyphDash;
    return GlyphBlank;
  endfunction

  // Columns of a glyph, leftmost column in the top byte.
  function automatic logic [39:0] glyph_row(input logic [5:0] idx);
    case (idx)
      6'd0:  return {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      6'd1:  return {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      6'd2:  return {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      6'd3:  return {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      6'd4:  return {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      6'd5:  return {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      6'd6:  return {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      6'd7:  return {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      6'd8:  return {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      6'd9:  return {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      6'd10: return {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      6'd11: return {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      6'd12: return {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      6'd13: return {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      6'd14: return {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      6'd15: return {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
      6'd16: return {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
      6'd17: return {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      6'd18: return {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      6'd19: return {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
      6'd20: return {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      6'd21: return {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      6'd22: return {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      6'd23: return {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      6'd24: return {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      6'd25: return {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      6'd26: return {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
      6'd27: return {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      6'd28: return {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      6'd29: return {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      6'd30: return {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      6'd31: return {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      6'd32: return {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
      6'd33: return {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      6'd34: return {8'h03, 8'h04, 8'h78, 8'h04, 8'h03};
      6'd35: return {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      6'd36: return {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      6'd37: return {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      default: return 40'h0;
    endcase
  endfunction

  // Byte k of a character cell; the sixth column is always blank.
  function automatic logic [7:0] glyph_byte(input logic [5:0] idx, input logic [2:0] k);
    logic [39:0] row;
    row = glyph_row(idx);
    case (k)
      3'd0: return row[39:32];
      3'd1: return row[31:24];
      3'd2: return row[23:16];
      3'd3: return row[15:8];
      3'd4: return row[7:0];
      default: return 8'h00;
    endcase
  endfunction

endpackage

[design/tgf_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package is used.
module tgf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/tgf_ctrl.sv]
// Command sequencer of the frame buffer: state machine and output valid flag.
// Depends on tgf_pkg for the state, command and control/status types.
module tgf_ctrl import tgf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        ctl_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.cmd)
          CMD_CLEAR:  state_d = ST_CLEAR;
          CMD_BORDER: state_d = ST_BORDER;
          CMD_CHAR: begin
            if (sts_i.glyph_ok) begin
              state_d = ST_GLYPH;
            end else begin
              ctl_o.rej_set = 1'b1;
              state_d       = ST_FINISH;
            end
          end
          CMD_NUMBER: begin
            ctl_o.rej_set = 1'b1;
            state_d       = sts_i.width_ok ? ST_CONV : ST_FINISH;
          end
          CMD_READ: begin
            if (sts_i.read_ok) begin
              state_d = ST_READ;
            end else begin
              ctl_o.rej_set = 1'b1;
              state_d       = ST_FINISH;
            end
          end
          default: begin
            ctl_o.rej_set = 1'b1;
            state_d       = ST_FINISH;
          end
        endcase
      end
      ST_CLEAR: begin
        ctl_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) state_d = ST_FINISH;
      end
      ST_BORDER: begin
        ctl_o.sweep_step   = 1'b1;
        ctl_o.sweep_border = 1'b1;
        if (sts_i.sweep_last) state_d = ST_FINISH;
      end
      ST_CONV: begin
        ctl_o.conv_step = 1'b1;
        if (sts_i.conv_last) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (sts_i.glyph_ok) begin
          ctl_o.digit_sel = 1'b1;
          ctl_o.rej_clr   = 1'b1;
          state_d         = ST_GLYPH;
        end else if (sts_i.digit_last) begin
          state_d = ST_FINISH;
        end else begin
          ctl_o.digit_next = 1'b1;
        end
      end
      ST_GLYPH: begin
        ctl_o.glyph_step = 1'b1;
        if (sts_i.glyph_last) begin
          if (sts_i.cmd == CMD_NUMBER && !sts_i.digit_last) begin
            ctl_o.digit_next = 1'b1;
            state_d          = ST_DIGIT;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_READ:  state_d = ST_RDATA;
      ST_RDATA: begin
        ctl_o.rd_capture = 1'b1;
        state_d          = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = ctl_o.out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

[design/tgf_datapath.sv]
// Datapath of the frame buffer: item registers, sweep counters, decimal
// converter, glyph writer and the frame store. Depends on tgf_pkg and tgf_ram.
module tgf_datapath import tgf_pkg::*; #(
  parameter int unsigned COLUMNS = ColumnsDefault,
  parameter int unsigned PAGES   = PagesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  column_i,
  input  logic [7:0]  page_row_i,
  input  logic [7:0]  char_code_i,
  input  logic [31:0] number_i,
  input  logic [7:0]  digit_count_i,
  output logic [7:0]  read_byte_o,
  output logic        rejected_o
);

  localparam int unsigned Depth   = COLUMNS * PAGES;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned PgW     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned ClW     = $clog2(COLUMNS);
  localparam int unsigned BcdW    = 4 * MaxDigits;
  localparam int unsigned BitW    = $clog2(NumBits);
  localparam int unsigned LastCol = COLUMNS - CellW;

  logic [2:0]      cmd_q;
  logic [7:0]      cur_col_q;
  logic [7:0]      page_q;
  logic [5:0]      gidx_q;
  logic [7:0]      digits_q;
  logic [3:0]      didx_q;
  logic [2:0]      k_q;
  logic [31:0]     bin_q;
  logic [BcdW-1:0] bcd_q;
  logic [BitW-1:0] bit_q;
  logic            rej_q;
  logic [7:0]      rd_q;
  logic [7:0]      out_byte_q;
  logic            out_rej_q;
  logic [PgW-1:0]  pg_cnt_q;
  logic [ClW-1:0]  col_cnt_q;

  logic [BcdW-1:0] bcd_adj;
  logic [3:0]      bcd_dig [MaxDigits];
  logic            col_last, pg_last;
  logic            sweep_we;
  logic [7:0]      sweep_data;
  logic [7:0]      col_k;
  logic [AddrW-1:0] sweep_addr, glyph_addr, addr;
  logic            ram_we;
  logic [7:0]      ram_wdata, ram_rdata;
  logic            page_ok;

  always_comb begin
    for (int i = 0; i < MaxDigits; i++) begin
      bcd_dig[i] = bcd_q[4*i +: 4];
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  assign col_last = (col_cnt_q == ClW'(COLUMNS - 1));
  assign pg_last  = (pg_cnt_q == PgW'(PAGES - 1));

  always_comb begin
    sweep_we   = 1'b1;
    sweep_data = 8'h00;
    if (ctl_i.sweep_border) begin
      if (col_cnt_q == '0 || col_last) begin
        sweep_data = SideCol;
      end else if (pg_last) begin
        sweep_data = RowBottom;
      end else if (pg_cnt_q == '0) begin
        sweep_data = RowTop;
      end else begin
        sweep_we = 1'b0;
      end
    end
  end

  assign col_k      = cur_col_q + {5'b0, k_q};
  assign sweep_addr = AddrW'(32'(pg_cnt_q) * COLUMNS + 32'(col_cnt_q));
  assign glyph_addr = AddrW'(32'(page_q[PgW-1:0]) * COLUMNS + 32'(col_k));
  assign addr       = ctl_i.sweep_step ? sweep_addr : glyph_addr;
  assign ram_we     = (ctl_i.sweep_step & sweep_we) | ctl_i.glyph_step;
  assign ram_wdata  = ctl_i.sweep_step ? sweep_data : glyph_byte(gidx_q, k_q);

  tgf_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr),
    .wdata_i(ram_wdata),
    .raddr_i(addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      bit_q     <= '0;
      pg_cnt_q  <= '0;
      col_cnt_q <= '0;
    end else begin
      if (ctl_i.sweep_step) begin
        if (col_last) begin
          col_cnt_q <= '0;
          pg_cnt_q  <= pg_last ? '0 : pg_cnt_q + PgW'(1);
        end else begin
          col_cnt_q <= col_cnt_q + ClW'(1);
        end
      end
      if (ctl_i.load) begin
        bit_q <= '0;
      end else if (ctl_i.conv_step) begin
        bit_q <= bit_q + BitW'(1);
      end
      if (ctl_i.load || ctl_i.digit_sel || ctl_i.digit_next) begin
        k_q <= '0;
      end else if (ctl_i.glyph_step) begin
        k_q <= (k_q == 3'(GlyphW)) ? 3'd0 : k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q     <= command_i;
      cur_col_q <= column_i;
      page_q    <= page_row_i;
      gidx_q    <= glyph_index(char_code_i);
      digits_q  <= digit_count_i;
      didx_q    <= 4'(digit_count_i - 8'd1);
      bin_q     <= number_i;
      bcd_q     <= '0;
      rej_q     <= 1'b0;
      rd_q      <= 8'h00;
    end else begin
      if (ctl_i.conv_step) begin
        bcd_q <= {bcd_adj[BcdW-2:0], bin_q[31]};
        bin_q <= {bin_q[30:0], 1'b0};
      end
      if (ctl_i.digit_sel) begin
        gidx_q <= {2'b00, bcd_dig[didx_q]};
      end
      if (ctl_i.digit_next) begin
        didx_q    <= didx_q - 4'd1;
        cur_col_q <= cur_col_q + 8'(CellW);
      end
      if (ctl_i.rej_set) begin
        rej_q <= 1'b1;
      end else if (ctl_i.rej_clr) begin
        rej_q <= 1'b0;
      end
      if (ctl_i.rd_capture) begin
        rd_q <= ram_rdata;
      end
    end
    if (ctl_i.out_load) begin
      out_byte_q <= rd_q;
      out_rej_q  <= rej_q;
    end
  end

  assign page_ok = (9'(page_q) < 9'(PAGES));

  assign sts_o.cmd        = cmd_q;
  assign sts_o.sweep_last = col_last & pg_last;
  assign sts_o.conv_last  = (bit_q == BitW'(NumBits - 1));
  assign sts_o.glyph_ok   = page_ok && (9'(cur_col_q) <= 9'(LastCol));
  assign sts_o.glyph_last = (k_q == 3'(GlyphW));
  assign sts_o.digit_last = (didx_q == 4'd0);
  assign sts_o.width_ok   = (digits_q != 8'd0) && (digits_q <= 8'(MaxDigits));
  assign sts_o.read_ok    = page_ok && (9'(cur_col_q) < 9'(COLUMNS));

  assign read_byte_o = out_byte_q;
  assign rejected_o  = out_rej_q;

endmodule

[design/text_glyph_framebuffer_core.sv]
// Top level of the text glyph frame buffer. One item is taken at a time: in_ready_o is high
// only while idle. A read, a character, a number (converted to decimal, then drawn digit by
// digit), a clear or a border is carried out after decode, and a command rejected at decode
// goes straight to finish, where the result waits until the output register is free; the
// single write port of the store sets the pace. After reset the store is swept to zero with
// in_ready_o low. Depends on tgf_pkg, tgf_ctrl and tgf_datapath.
module text_glyph_framebuffer_core import tgf_pkg::*; #(
  parameter int unsigned COLUMNS = ColumnsDefault,
  parameter int unsigned PAGES   = PagesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  column_i,
  input  logic [7:0]  page_row_i,
  input  logic [7:0]  char_code_i,
  input  logic [31:0] number_i,
  input  logic [7:0]  digit_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_byte_o,
  output logic        rejected_o
);

  ctl_t ctl;
  sts_t sts;

  tgf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  tgf_datapath #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .command_i    (command_i),
    .column_i     (column_i),
    .page_row_i   (page_row_i),
    .char_code_i  (char_code_i),
    .number_i     (number_i),
    .digit_count_i(digit_count_i),
    .read_byte_o  (read_byte_o),
    .rejected_o   (rejected_o)
  );

endmodule
